// ----- rtl/twcs_pkg.sv -----
// Shared widths, reset values and the result bundle of the two-wire character sender.
`default_nettype none

package twcs_pkg;

    localparam int unsigned CharW  = 7;
    localparam int unsigned DelayW = 16;
    localparam int unsigned TickW  = 18;
    localparam int unsigned PhaseW = 5;
    localparam int unsigned BitIdxW = 3;

    localparam logic [DelayW-1:0] BitDelayReset = 16'd100;
    localparam logic [DelayW-1:0] GapReset      = 16'd2000;

    // Register indexes on the configuration port
    localparam logic CfgBitDelay = 1'b0;
    localparam logic CfgGap      = 1'b1;

    // Line levels and pulses after one item
    typedef struct packed {
        logic frame_done;
        logic char_acked;
        logic want_char;
        logic data_drive;
        logic data_out;
        logic clock_out;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/twcs_core.sv -----
// Phase sequencer of the two-wire sender: state update and line levels for one item.
`default_nettype none

module twcs_core
    import twcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_action,
    input  wire logic [CharW-1:0]  i_char_value,
    input  wire logic              i_char_is_last,
    input  wire logic              i_data_line_in,
    input  wire logic [DelayW-1:0] i_bit_delay,
    input  wire logic [DelayW-1:0] i_gap,
    output t_result                o_result
);

    localparam logic [PhaseW-1:0] PH_IDLE       = 5'd0;
    localparam logic [PhaseW-1:0] PH_WAIT       = 5'd1;
    localparam logic [PhaseW-1:0] PH_START_HIGH = 5'd2;
    localparam logic [PhaseW-1:0] PH_START_GAP  = 5'd3;
    localparam logic [PhaseW-1:0] PH_BIT0       = 5'd4;
    localparam logic [PhaseW-1:0] PH_BIT1       = 5'd5;
    localparam logic [PhaseW-1:0] PH_BIT2       = 5'd6;
    localparam logic [PhaseW-1:0] PH_BIT3       = 5'd7;
    localparam logic [PhaseW-1:0] PH_PAR0       = 5'd8;
    localparam logic [PhaseW-1:0] PH_PAR1       = 5'd9;
    localparam logic [PhaseW-1:0] PH_PAR2       = 5'd10;
    localparam logic [PhaseW-1:0] PH_ACK0       = 5'd11;
    localparam logic [PhaseW-1:0] PH_ACK1       = 5'd12;
    localparam logic [PhaseW-1:0] PH_ACK2       = 5'd13;
    localparam logic [PhaseW-1:0] PH_ACK_SAMPLE = 5'd14;
    localparam logic [PhaseW-1:0] PH_ACK4       = 5'd15;
    localparam logic [PhaseW-1:0] PH_ACK5       = 5'd16;
    localparam logic [PhaseW-1:0] PH_ACK6       = 5'd17;
    localparam logic [PhaseW-1:0] PH_END0       = 5'd18;
    localparam logic [PhaseW-1:0] PH_END1       = 5'd19;
    localparam logic [PhaseW-1:0] PH_END2       = 5'd20;
    localparam logic [BitIdxW-1:0] LastBit      = BitIdxW'(CharW - 1);

    logic [PhaseW-1:0]  r_phase, n_phase;
    logic [TickW-1:0]   r_tick, n_tick;
    logic [BitIdxW-1:0] r_bit_idx, n_bit_idx;
    logic [CharW-1:0]   r_char, n_char;
    logic               r_last, n_last;
    logic               r_parity, n_parity;
    logic               r_ack, n_ack;

    logic [DelayW-1:0]  delay_eff;
    logic [DelayW-1:0]  gap_eff;
    logic [TickW-1:0]   phase_len;
    logic [TickW-1:0]   tick_inc;
    logic               busy;
    logic               ack_pulse;
    logic               done_pulse;
    logic [BitIdxW-1:0] bit_sel;
    logic [CharW:0]     char_ext;
    logic               cur_bit;
    logic               par_bit;

    // A zero delay register acts as one tick
    assign delay_eff = (i_bit_delay == '0) ? DelayW'(1) : i_bit_delay;
    assign gap_eff   = (i_gap == '0) ? DelayW'(1) : i_gap;
    assign busy      = (r_phase != PH_IDLE) && (r_phase != PH_WAIT);
    assign tick_inc  = r_tick + TickW'(1);

    // Length of the current phase in ticks
    always_comb begin
        if (r_phase == PH_START_GAP || r_phase == PH_END0 || r_phase == PH_END1) begin
            phase_len = TickW'(gap_eff);
        end else if (r_phase == PH_ACK_SAMPLE) begin
            phase_len = {delay_eff, 2'b00};
        end else begin
            phase_len = TickW'(delay_eff);
        end
    end

    // Next state for one item
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit_idx  = r_bit_idx;
        n_char     = r_char;
        n_last     = r_last;
        n_parity   = r_parity;
        n_ack      = r_ack;
        ack_pulse  = 1'b0;
        done_pulse = 1'b0;
        if (i_action) begin
            // load is taken only while idle or between characters
            if (!busy) begin
                n_char    = i_char_value;
                n_last    = i_char_is_last;
                n_parity  = ^i_char_value;
                n_ack     = 1'b0;
                n_bit_idx = '0;
                n_tick    = '0;
                n_phase   = (r_phase == PH_IDLE) ? PH_START_HIGH : PH_BIT0;
            end
        end else if (busy) begin
            n_tick = tick_inc;
            if (tick_inc >= phase_len) begin
                n_tick = '0;
                case (r_phase)
                    PH_START_HIGH: n_phase = PH_START_GAP;
                    PH_START_GAP: begin
                        n_bit_idx = '0;
                        n_phase   = PH_BIT0;
                    end
                    PH_BIT3: begin
                        if (r_bit_idx >= LastBit) begin
                            n_bit_idx = '0;
                            n_phase   = PH_PAR0;
                        end else begin
                            n_bit_idx = r_bit_idx + BitIdxW'(1);
                            n_phase   = PH_BIT0;
                        end
                    end
                    PH_PAR2: n_phase = PH_ACK0;
                    PH_ACK_SAMPLE: begin
                        n_ack     = i_data_line_in;
                        ack_pulse = i_data_line_in;
                        n_phase   = PH_ACK4;
                    end
                    PH_ACK6: begin
                        if (!r_ack) begin
                            // receiver refused: resend the same character
                            n_bit_idx = '0;
                            n_phase   = PH_BIT0;
                        end else if (r_last) begin
                            n_phase = PH_END0;
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_END2: begin
                        n_last     = 1'b0;
                        done_pulse = 1'b1;
                        n_phase    = PH_IDLE;
                    end
                    default: begin
                        if (r_phase >= PH_BIT0 && r_phase < PH_END2) begin
                            n_phase = r_phase + PhaseW'(1);
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Data bit of the new state, MSB first
    assign bit_sel  = LastBit - n_bit_idx;
    assign char_ext = {1'b0, n_char};
    assign cur_bit  = char_ext[bit_sel];
    assign par_bit  = ~n_parity;

    // Line levels after the step
    always_comb begin
        o_result            = '0;
        o_result.data_drive = 1'b1;
        o_result.char_acked = ack_pulse;
        o_result.frame_done = done_pulse;
        o_result.want_char  = (n_phase == PH_IDLE) || (n_phase == PH_WAIT);
        case (n_phase)
            PH_IDLE:       o_result.data_drive = 1'b0;
            PH_WAIT:       o_result.clock_out = 1'b1;
            PH_START_HIGH: o_result.clock_out = 1'b1;
            PH_BIT1:       o_result.data_out = cur_bit;
            PH_BIT2: begin
                o_result.clock_out = 1'b1;
                o_result.data_out  = cur_bit;
            end
            PH_BIT3:       o_result.clock_out = 1'b1;
            PH_PAR1:       o_result.data_out = par_bit;
            PH_PAR2: begin
                o_result.clock_out = 1'b1;
                o_result.data_out  = par_bit;
            end
            PH_ACK0:       o_result.data_out = par_bit;
            PH_ACK1:       o_result.data_out = 1'b1;
            PH_ACK_SAMPLE: o_result.data_drive = 1'b0;
            PH_ACK4:       o_result.data_drive = 1'b0;
            PH_ACK5: begin
                o_result.clock_out  = 1'b1;
                o_result.data_drive = 1'b0;
            end
            PH_ACK6:       o_result.clock_out = 1'b1;
            PH_END0:       o_result.clock_out = 1'b1;
            PH_END1: begin
                o_result.clock_out = 1'b1;
                o_result.data_out  = 1'b1;
            end
            PH_END2:       o_result.clock_out = 1'b1;
            default: ;
        endcase
    end

    // State registers advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_char    <= '0;
            r_last    <= 1'b0;
            r_parity  <= 1'b0;
            r_ack     <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_char    <= n_char;
            r_last    <= n_last;
            r_parity  <= n_parity;
            r_ack     <= n_ack;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/two_wire_char_sender_with_ack_unit.sv -----
// Top level of the two-wire character sender: stream ports, registers, result register.
//
// Usage: every input item is either one timer tick (tuser = 0) or a character
// load (tuser = 1, character in tdata[6:0], tlast marks the last character of
// the frame). tdata[7] carries the sampled data line for the acknowledge slot.
// Each input item yields exactly one result item with the clock and data line
// levels, the data drive enable, the want-character flag and the acknowledge
// pulse in tdata, and the end-of-frame pulse in tlast.
// The phase sequencer updates its state on the accepting edge, and the levels
// are loaded into the result register on that same edge.
// Throughput is one item per cycle; the result register lets a new item in
// whenever it is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and s_axis_tready drops once the
// result register is full. Reset puts the sequencer in idle, loads the
// register defaults (bit delay 100 ticks, gap 2000 ticks) and empties the
// result register. Register writes take effect at once.
`default_nettype none

module two_wire_char_sender_with_ack_unit
    import twcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [DelayW-1:0] i_cfg_wdata,
    // input items
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [6:0] char_value, [7] data_line_in
    input  wire logic              s_axis_tuser,   // action
    input  wire logic              s_axis_tlast,   // char_is_last
    // result items
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [0] clock_out, [1] data_out,
                                                   // [2] data_drive, [3] want_char,
                                                   // [4] char_acked, [7:5] zero
    output logic                   m_axis_tlast    // frame_done
);

    logic [DelayW-1:0] r_bit_delay;
    logic [DelayW-1:0] r_gap;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_delay <= BitDelayReset;
            r_gap       <= GapReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgBitDelay: r_bit_delay <= i_cfg_wdata;
                CfgGap:      r_gap       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    twcs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (accept),
        .i_action       (s_axis_tuser),
        .i_char_value   (s_axis_tdata[CharW-1:0]),
        .i_char_is_last (s_axis_tlast),
        .i_data_line_in (s_axis_tdata[7]),
        .i_bit_delay    (r_bit_delay),
        .i_gap          (r_gap),
        .o_result       (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.char_acked, r_out.want_char, r_out.data_drive,
                            r_out.data_out, r_out.clock_out};
    assign m_axis_tlast  = r_out.frame_done;

endmodule

`default_nettype wire
